>>> rtl/core/hstb_pkg.sv
// ----------------------------------------------------------------------------
// hstb_pkg
// Shared types, constants and the digit-pairing step for the hex string decoder.
// ----------------------------------------------------------------------------
package hstb_pkg;

    localparam int          MAX_LEN_DEFAULT = 65536;
    localparam int          MID_DEPTH       = 4;
    localparam int          OUT_DEPTH       = 2;
    localparam logic [15:0] IDX_MAX         = 16'hFFFF;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LF    = 8'h66;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;
    localparam logic [7:0] CH_LX    = 8'h78;
    localparam logic [7:0] CH_UX    = 8'h58;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;

    typedef enum logic [1:0] {
        STATUS_OK  = 2'd0,
        STATUS_ODD = 2'd1,
        STATUS_BAD = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        PH_LEAD  = 2'd0,
        PH_FIRST = 2'd1,
        PH_BODY  = 2'd2
    } phase_t;

    typedef struct packed {
        logic [7:0] char_code;
        logic       last_char;
    } in_item_t;

    typedef struct packed {
        logic        byte_valid;
        logic [7:0]  byte_value;
        logic        finished;
        status_t     status;
        logic [15:0] error_index;
    } out_item_t;

    // classified character
    typedef struct packed {
        logic       ws;
        logic       hex_ok;
        logic [3:0] nib;
        logic       is_x;
        logic       last;
    } cls_t;

    typedef struct packed {
        logic        half;
        logic [3:0]  high;
        logic [15:0] pair_start;
        logic        bad;
        logic [15:0] bad_index;
        logic        odd;
    } dstate_t;

    typedef struct packed {
        dstate_t    s;
        logic       got;
        logic [7:0] bval;
    } dstep_t;

    function automatic dstep_t take_digit(dstate_t s, logic ok, logic [3:0] nib,
                                          logic [15:0] idx);
        dstep_t r;
        r      = '0;
        r.s    = s;
        r.s.odd = ~s.odd;
        if (!s.half) begin
            r.s.half = 1'b1;
            if (!s.bad) begin
                r.s.pair_start = idx;
                if (!ok) begin
                    r.s.bad       = 1'b1;
                    r.s.bad_index = idx;
                end else begin
                    r.s.high = nib;
                end
            end
        end else begin
            r.s.half = 1'b0;
            if (!s.bad) begin
                if (!ok) begin
                    r.s.bad       = 1'b1;
                    r.s.bad_index = s.pair_start;
                end else begin
                    r.got  = 1'b1;
                    r.bval = {s.high, nib};
                end
            end
        end
        return r;
    endfunction

endpackage

>>> rtl/core/hex_string_to_bytes.sv
// ----------------------------------------------------------------------------
// hex_string_to_bytes
// Streaming hex text to byte decoder with queue-style ports.
// ----------------------------------------------------------------------------
// Takes one character per cycle while full is low, and returns one result
// per completed byte or per final character. A classified character enters
// a four-entry queue; when the decoder pops it, the decoder updates its state
// and writes any result into a two-entry result queue at the same edge. The
// sustained rate is one character per cycle while results are popped and the
// result queue does not fill. Odd digit count outranks an invalid character;
// on an odd count, bytes already delivered for that string should be discarded.
// The block returns to its initial state after each final character.
module hex_string_to_bytes
    import hstb_pkg::*;
#(
    parameter int MAX_LEN = MAX_LEN_DEFAULT
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  in_item_t  item,
    output logic      full,
    input  logic      pop,
    output out_item_t result,
    output logic      empty
);

    logic      cls_push, cls_full, cls_pop, cls_empty;
    cls_t      cls_wr, cls_rd;
    out_item_t res_wr;
    logic      res_push, res_full;

    hstb_front u_front (
        .push     (push),
        .item     (item),
        .full     (full),
        .cls_push (cls_push),
        .cls_item (cls_wr),
        .cls_full (cls_full)
    );

    hstb_fifo #(
        .WIDTH ($bits(cls_t)),
        .DEPTH (MID_DEPTH)
    ) u_mid_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (cls_push),
        .wdata (cls_wr),
        .full  (cls_full),
        .pop   (cls_pop),
        .rdata (cls_rd),
        .empty (cls_empty)
    );

    hstb_back #(
        .MAX_LEN (MAX_LEN)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cls       (cls_rd),
        .cls_empty (cls_empty),
        .cls_pop   (cls_pop),
        .res       (res_wr),
        .res_push  (res_push),
        .res_full  (res_full)
    );

    hstb_fifo #(
        .WIDTH ($bits(out_item_t)),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res_wr),
        .full  (res_full),
        .pop   (pop),
        .rdata (result),
        .empty (empty)
    );

endmodule

>>> rtl/core/hstb_fifo.sv
// ----------------------------------------------------------------------------
// hstb_fifo
// Small flip-flop queue with push/full and pop/empty handshakes.
// ----------------------------------------------------------------------------
module hstb_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == FULL_CNT);
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

>>> rtl/core/hstb_front.sv
// ----------------------------------------------------------------------------
// hstb_front
// Accepts characters and classifies them: whitespace, hex digit value, x/X.
// ----------------------------------------------------------------------------
module hstb_front
    import hstb_pkg::*;
(
    input  logic     push,
    input  in_item_t item,
    output logic     full,
    output logic     cls_push,
    output cls_t     cls_item,
    input  logic     cls_full
);

    logic [7:0] c;

    assign c        = item.char_code;
    assign full     = cls_full;
    assign cls_push = push;

    always_comb
    begin
        cls_item      = '0;
        cls_item.last = item.last_char;
        cls_item.ws   = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
        cls_item.is_x = (c == CH_LX) || (c == CH_UX);
        if (c >= CH_ZERO && c <= CH_NINE)
        begin
            cls_item.hex_ok = 1'b1;
            cls_item.nib    = 4'(c - CH_ZERO);
        end
        else if (c >= CH_LA && c <= CH_LF)
        begin
            cls_item.hex_ok = 1'b1;
            cls_item.nib    = 4'(c - CH_LA + 8'd10);
        end
        else if (c >= CH_UA && c <= CH_UF)
        begin
            cls_item.hex_ok = 1'b1;
            cls_item.nib    = 4'(c - CH_UA + 8'd10);
        end
    end

endmodule

>>> rtl/core/hstb_back.sv
// ----------------------------------------------------------------------------
// hstb_back
// Decoder state: prefix handling, held whitespace, digit pairing and status.
// ----------------------------------------------------------------------------
module hstb_back
    import hstb_pkg::*;
#(
    parameter int MAX_LEN = MAX_LEN_DEFAULT
) (
    input  logic      clk,
    input  logic      rst_n,
    input  cls_t      cls,
    input  logic      cls_empty,
    output logic      cls_pop,
    output out_item_t res,
    output logic      res_push,
    input  logic      res_full
);

    localparam logic [15:0] IDX_LIMIT =
        (MAX_LEN - 1 > 65535) ? IDX_MAX : 16'(MAX_LEN - 1);

    phase_t      phase_reg, phase_next;
    logic [15:0] idx_reg, idx_next;
    logic        fvalid_reg, fvalid_next;
    logic [3:0]  fnib_reg, fnib_next;
    dstate_t     ds_reg, ds_next;
    logic        held_reg, held_next;
    logic [15:0] held_idx_reg, held_idx_next;
    logic        held_par_reg, held_par_next;

    logic        step;
    logic        produce;
    logic        got;
    logic [7:0]  bval;
    dstep_t      st;
    dstate_t     s;
    logic        rest;
    status_t     stat;

    always_comb
    begin
        phase_next    = phase_reg;
        fvalid_next   = fvalid_reg;
        fnib_next     = fnib_reg;
        held_next     = held_reg;
        held_idx_next = held_idx_reg;
        held_par_next = held_par_reg;
        s             = ds_reg;
        got           = 1'b0;
        bval          = '0;
        st            = '0;
        rest          = 1'b0;
        stat          = STATUS_OK;

        unique case (phase_reg)
            PH_LEAD:
            begin
                if (!cls.ws)
                begin
                    phase_next   = PH_FIRST;
                    fvalid_next  = cls.hex_ok;
                    fnib_next    = cls.nib;
                    s.pair_start = idx_reg;
                end
            end
            PH_FIRST:
            begin
                phase_next = PH_BODY;
                if (!(fvalid_reg && fnib_reg == 4'd0 && cls.is_x))
                begin
                    st = take_digit(s, fvalid_reg, fnib_reg, s.pair_start);
                    s  = st.s;
                    if (cls.ws)
                    begin
                        held_next     = 1'b1;
                        held_idx_next = idx_reg;
                        held_par_next = 1'b1;
                    end
                    else
                    begin
                        st   = take_digit(s, cls.hex_ok, cls.nib, idx_reg);
                        s    = st.s;
                        got  = st.got;
                        bval = st.bval;
                    end
                end
            end
            PH_BODY:
            begin
                if (cls.ws)
                begin
                    if (!held_reg)
                    begin
                        held_idx_next = idx_reg;
                    end
                    held_next     = 1'b1;
                    held_par_next = ~held_par_reg;
                end
                else
                begin
                    if (held_reg)
                    begin
                        st     = take_digit(s, 1'b0, 4'd0, held_idx_reg);
                        s      = st.s;
                        rest   = ~held_par_reg;
                        s.half = s.half ^ rest;
                        s.odd  = s.odd ^ rest;
                    end
                    held_next     = 1'b0;
                    held_par_next = 1'b0;
                    st            = take_digit(s, cls.hex_ok, cls.nib, idx_reg);
                    s             = st.s;
                    got           = st.got;
                    bval          = st.bval;
                end
            end
            default:
            begin
                phase_next = PH_LEAD;
            end
        endcase

        ds_next  = s;
        idx_next = (idx_reg < IDX_LIMIT) ? idx_reg + 16'd1 : idx_reg;

        if (phase_next == PH_FIRST || s.odd)
        begin
            stat = STATUS_ODD;
        end
        else if (s.bad)
        begin
            stat = STATUS_BAD;
        end

        res             = '0;
        res.byte_valid  = got;
        res.byte_value  = bval;
        res.finished    = cls.last;
        if (cls.last)
        begin
            res.status      = stat;
            res.error_index = (stat == STATUS_BAD) ? s.bad_index : 16'd0;
            phase_next      = PH_LEAD;
            idx_next        = '0;
            fvalid_next     = 1'b0;
            fnib_next       = '0;
            ds_next         = '0;
            held_next       = 1'b0;
            held_idx_next   = '0;
            held_par_next   = 1'b0;
        end

        produce  = got || cls.last;
        cls_pop  = !cls_empty && (!produce || !res_full);
        step     = cls_pop;
        res_push = cls_pop && produce;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_LEAD;
            idx_reg      <= '0;
            fvalid_reg   <= 1'b0;
            fnib_reg     <= '0;
            ds_reg       <= '0;
            held_reg     <= 1'b0;
            held_idx_reg <= '0;
            held_par_reg <= 1'b0;
        end
        else if (step)
        begin
            phase_reg    <= phase_next;
            idx_reg      <= idx_next;
            fvalid_reg   <= fvalid_next;
            fnib_reg     <= fnib_next;
            ds_reg       <= ds_next;
            held_reg     <= held_next;
            held_idx_reg <= held_idx_next;
            held_par_reg <= held_par_next;
        end
    end

endmodule

>>> rtl/core/hstb_checker.sv
// ----------------------------------------------------------------------------
// hstb_checker
// Port-level checks for the hex string decoder, bound to the top level.
// ----------------------------------------------------------------------------
module hstb_checker
    import hstb_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      push,
    input in_item_t  item,
    input logic      full,
    input logic      pop,
    input out_item_t result,
    input logic      empty
);

    // every result carries a byte or closes a string
    a_res_has_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (result.byte_valid || result.finished))
        else $error("result with neither byte nor finish");

    a_mid_status_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !result.finished) |-> (result.status == STATUS_OK))
        else $error("status set on a non-final transaction");

    a_index_only_bad: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.status != STATUS_BAD) |-> (result.error_index == 16'd0))
        else $error("error index without invalid status");

    a_no_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !result.byte_valid) |-> (result.byte_value == 8'd0))
        else $error("byte value set without byte_valid");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(result)))
        else $error("waiting transaction changed");

endmodule

bind hex_string_to_bytes hstb_checker u_hstb_checker (.*);

>>> sim/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for the hex_string_to_bytes decoder.
// ----------------------------------------------------------------------------
// Drives character strings through the push/full side and pops results on the
// empty/pop side, with random idle bursts on both sides. A typed table covers
// leading and trailing whitespace, both prefix forms, a lone digit, bad
// characters and whitespace inside the digits. Random well-formed, corrupted
// and noise strings follow. Each popped transaction is compared field by
// field against a typed row's want, else a behavioral decoder model here.
// ----------------------------------------------------------------------------
module tb;
    import hstb_pkg::*;

    localparam int          RANDOM_CHARS = 1150;
    localparam int          CALM_CHARS   = 200;
    localparam logic [15:0] POS_CAP      = (MAX_LEN_DEFAULT - 1 > 65535) ? 16'hFFFF
                                           : 16'(MAX_LEN_DEFAULT - 1);

    typedef struct packed {
        logic [15:0] pos;
        logic        begun;
        logic        prefix_done;
        logic        half;
        logic [3:0]  hi;
        logic [7:0]  held;
        logic [15:0] pair_at;
        logic [15:0] ws_run;
        logic [15:0] ws_at;
        logic        ws_par;
        logic        broken;
        logic [15:0] broken_at;
        logic        odd;
    } decode_state_t;

    typedef struct packed {
        in_item_t  it;
        logic      typed;
        out_item_t want;
    } text_row_t;

    logic      clk;
    logic      rst_n;
    logic      push;
    in_item_t  item;
    logic      full;
    logic      pop;
    out_item_t result;
    logic      empty;

    decode_state_t ds;
    out_item_t     byte_q[$];
    text_row_t     directed_text[$];
    int            err_cnt;
    int            sent;
    logic          quiet;
    int            rx_hold;

    hex_string_to_bytes #(
        .MAX_LEN(MAX_LEN_DEFAULT)
    ) u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .item   (item),
        .full   (full),
        .pop    (pop),
        .result (result),
        .empty  (empty)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #80_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    task automatic flag_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
        $display("MISMATCH %s: got %0h want %0h at %0t", what, got, want, $realtime);
        err_cnt++;
    endtask

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

    // bit 4 set: not a hex digit
    function automatic logic [4:0] nibble_of(input logic [7:0] c);
        if (c >= CH_ZERO && c <= CH_NINE) return {1'b0, 4'(c - CH_ZERO)};
        if (c >= CH_LA && c <= CH_LF) return {1'b0, 4'(c - CH_LA + 8'd10)};
        if (c >= CH_UA && c <= CH_UF) return {1'b0, 4'(c - CH_UA + 8'd10)};
        return 5'h10;
    endfunction

    task automatic feed_digit(input logic [7:0] c, input logic [15:0] at,
                              output logic got, output logic [7:0] val);
        logic [4:0] v;
        v   = nibble_of(c);
        got = 1'b0;
        val = 8'h00;
        ds.odd = ~ds.odd;
        if (!ds.half)
        begin
            ds.half = 1'b1;
            if (!ds.broken)
            begin
                ds.pair_at = at;
                if (v[4])
                begin
                    ds.broken    = 1'b1;
                    ds.broken_at = at;
                end
                else
                begin
                    ds.hi = v[3:0];
                end
            end
        end
        else
        begin
            ds.half = 1'b0;
            if (!ds.broken)
            begin
                if (v[4])
                begin
                    ds.broken    = 1'b1;
                    ds.broken_at = ds.pair_at;
                end
                else
                begin
                    got = 1'b1;
                    val = {ds.hi, v[3:0]};
                end
            end
        end
    endtask

    task automatic hold_space(input logic [15:0] at);
        if (ds.ws_run == 16'd0) ds.ws_at = at;
        if (ds.ws_run != 16'hFFFF) ds.ws_run++;
        ds.ws_par = ~ds.ws_par;
    endtask

    // held whitespace followed by text: all of it is invalid digits
    task automatic flush_spaces();
        logic       g;
        logic [7:0] v;
        logic       rest;
        if (ds.ws_run != 16'd0)
        begin
            feed_digit(CH_SPACE, ds.ws_at, g, v);
            rest      = ~ds.ws_par;
            ds.half   = ds.half ^ rest;
            ds.odd    = ds.odd ^ rest;
            ds.ws_run = 16'd0;
            ds.ws_par = 1'b0;
        end
    endtask

    task automatic decode_char(input in_item_t it, output logic has, output out_item_t r);
        logic        got;
        logic [7:0]  val;
        logic        g0;
        logic [7:0]  v0;
        logic [15:0] at;
        logic        sp;
        got = 1'b0;
        val = 8'h00;
        at  = ds.pos;
        sp  = is_space(it.char_code);
        if (!ds.begun)
        begin
            if (!sp)
            begin
                ds.begun   = 1'b1;
                ds.held    = it.char_code;
                ds.pair_at = at;
            end
        end
        else if (!ds.prefix_done)
        begin
            ds.prefix_done = 1'b1;
            if (!(ds.held == CH_ZERO && (it.char_code == CH_LX || it.char_code == CH_UX)))
            begin
                feed_digit(ds.held, ds.pair_at, g0, v0);
                if (sp) hold_space(at);
                else feed_digit(it.char_code, at, got, val);
            end
        end
        else if (sp)
        begin
            hold_space(at);
        end
        else
        begin
            flush_spaces();
            feed_digit(it.char_code, at, got, val);
        end
        if (ds.pos < POS_CAP) ds.pos++;

        has = got || it.last_char;
        r   = '0;
        r.byte_valid = got;
        r.byte_value = got ? val : 8'h00;
        r.finished   = it.last_char;
        r.status     = STATUS_OK;
        if (it.last_char)
        begin
            if (ds.begun && !ds.prefix_done) r.status = STATUS_ODD;
            else if (ds.odd) r.status = STATUS_ODD;
            else if (ds.broken) r.status = STATUS_BAD;
            r.error_index = (r.status == STATUS_BAD) ? ds.broken_at : 16'd0;
            ds = '0;
        end
    endtask

    // entered just after a falling edge; returns just after a falling edge
    task automatic send_char(input in_item_t it, input logic typed, input out_item_t want);
        logic      has;
        out_item_t r;
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge clk);
        end
        push <= 1'b1;
        item <= it;
        @(posedge clk);
        while (full) @(posedge clk);
        decode_char(it, has, r);
        if (typed) byte_q = {byte_q, want};
        else if (has) byte_q = {byte_q, r};
        sent++;
        @(negedge clk);
    endtask

    function automatic logic [7:0] rand_hex();
        int v;
        v = $urandom_range(0, 21);
        if (v < 10) return CH_ZERO + 8'(v);
        if (v < 16) return CH_LA + 8'(v - 10);
        return CH_UA + 8'(v - 16);
    endfunction

    function automatic logic [7:0] rand_ws();
        int v;
        v = $urandom_range(0, 5);
        return (v == 5) ? CH_SPACE : CH_TAB + 8'(v);
    endfunction

    task automatic send_string();
        logic [7:0] txt[$];
        int         kind;
        int         n;
        int         k;
        in_item_t   it;
        kind = $urandom_range(0, 9);
        n = $urandom_range(0, 2);
        repeat (n) txt = {txt, rand_ws()};
        if ($urandom_range(0, 1))
        begin
            txt = {txt, CH_ZERO};
            txt = {txt, ($urandom_range(0, 1) ? CH_LX : CH_UX)};
        end
        n = 2 * $urandom_range(0, 6);
        repeat (n) txt = {txt, rand_hex()};
        n = $urandom_range(0, 2);
        repeat (n) txt = {txt, rand_ws()};
        case (kind)
            7:
            begin
                if (txt.size() > 0)
                    txt[$urandom_range(0, txt.size() - 1)] = 8'($urandom_range(0, 255));
            end
            8:
            begin
                txt.insert($urandom_range(0, txt.size()),
                           $urandom_range(0, 1) ? rand_ws() : rand_hex());
            end
            9:
            begin
                txt.delete();
                n = $urandom_range(1, 10);
                repeat (n) txt = {txt, 8'($urandom_range(0, 255))};
            end
            default: ;
        endcase
        if (txt.size() == 0) txt = {txt, CH_SPACE};
        for (k = 0; k < txt.size(); k++)
        begin
            it.char_code = txt[k];
            it.last_char = (k == txt.size() - 1);
            send_char(it, 1'b0, '0);
        end
    endtask

    function automatic text_row_t row(input logic [7:0] c, input logic l);
        text_row_t t;
        t = '0;
        t.it.char_code = c;
        t.it.last_char = l;
        return t;
    endfunction

    function automatic text_row_t row_typed(input logic [7:0] c, input logic bv,
                                            input logic [7:0] v, input status_t st,
                                            input logic [15:0] ei);
        text_row_t t;
        t = row(c, 1'b1);
        t.typed            = 1'b1;
        t.want.byte_valid  = bv;
        t.want.byte_value  = v;
        t.want.finished    = 1'b1;
        t.want.status      = st;
        t.want.error_index = ei;
        return t;
    endfunction

    // result side: random pop stalls
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            pop     <= 1'b0;
            rx_hold <= 0;
        end
        else if (quiet)
        begin
            pop <= 1'b1;
        end
        else if (rx_hold > 0)
        begin
            pop     <= 1'b0;
            rx_hold <= rx_hold - 1;
        end
        else if ($urandom_range(0, 5) == 0)
        begin
            pop     <= 1'b0;
            rx_hold <= $urandom_range(0, 4);
        end
        else
        begin
            pop <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        out_item_t w;
        if (rst_n && pop && !empty)
        begin
            if (byte_q.size() == 0)
            begin
                flag_mismatch("transaction with none expected", 16'(result.byte_value), 16'd0);
            end
            else
            begin
                w = byte_q.pop_front();
                if (result.byte_valid !== w.byte_valid)
                    flag_mismatch("byte_valid", 16'(result.byte_valid), 16'(w.byte_valid));
                if (result.byte_value !== w.byte_value)
                    flag_mismatch("byte_value", 16'(result.byte_value), 16'(w.byte_value));
                if (result.finished !== w.finished)
                    flag_mismatch("finished", 16'(result.finished), 16'(w.finished));
                if (result.status !== w.status)
                    flag_mismatch("status", 16'(result.status), 16'(w.status));
                if (result.error_index !== w.error_index)
                    flag_mismatch("error_index", result.error_index, w.error_index);
            end
        end
    end

    initial
    begin
        int k;
        int mark;
        err_cnt = 0;
        sent    = 0;
        quiet   = 1'b0;
        ds      = '0;
        rst_n   = 1'b0;
        push    = 1'b0;
        item    = '0;

        // whitespace only
        directed_text = {directed_text, row_typed(CH_SPACE, 1'b0, 8'h00, STATUS_OK, 16'd0)};
        // lower-case prefix, mixed-case digits
        directed_text = {directed_text, row(CH_ZERO, 1'b0)};
        directed_text = {directed_text, row(CH_LX, 1'b0)};
        directed_text = {directed_text, row(CH_LF, 1'b0)};
        directed_text = {directed_text, row_typed(CH_UF, 1'b1, 8'hFF, STATUS_OK, 16'd0)};
        // upper-case prefix
        directed_text = {directed_text, row(CH_ZERO, 1'b0)};
        directed_text = {directed_text, row(CH_UX, 1'b0)};
        directed_text = {directed_text, row(CH_ZERO, 1'b0)};
        directed_text = {directed_text, row_typed(CH_ZERO, 1'b1, 8'h00, STATUS_OK, 16'd0)};
        // leading whitespace, lone held digit
        directed_text = {directed_text, row(CH_TAB, 1'b0)};
        directed_text = {directed_text, row(CH_CR, 1'b0)};
        directed_text = {directed_text, row_typed(CH_UA, 1'b0, 8'h00, STATUS_ODD, 16'd0)};
        // trailing whitespace
        directed_text = {directed_text, row(CH_ZERO + 8'd1, 1'b0)};
        directed_text = {directed_text, row(CH_ZERO + 8'd2, 1'b0)};
        directed_text = {directed_text, row(8'h0A, 1'b1)};
        // whitespace inside the digits
        directed_text = {directed_text, row(CH_ZERO + 8'd1, 1'b0)};
        directed_text = {directed_text, row(CH_SPACE, 1'b0)};
        directed_text = {directed_text, row(CH_ZERO + 8'd2, 1'b1)};
        // code extremes, both invalid
        directed_text = {directed_text, row(8'hFF, 1'b0)};
        directed_text = {directed_text, row_typed(8'h00, 1'b0, 8'h00, STATUS_BAD, 16'd0)};
        // prefix only
        directed_text = {directed_text, row(CH_ZERO, 1'b0)};
        directed_text = {directed_text, row_typed(CH_LX, 1'b0, 8'h00, STATUS_OK, 16'd0)};
        // two whitespace chars held inside the digits
        directed_text = {directed_text, row(CH_LA, 1'b0)};
        directed_text = {directed_text, row(8'h0B, 1'b0)};
        directed_text = {directed_text, row(8'h0C, 1'b0)};
        directed_text = {directed_text, row(CH_LA + 8'd1, 1'b1)};

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (k = 0; k < directed_text.size(); k++)
            send_char(directed_text[k].it, directed_text[k].typed, directed_text[k].want);

        mark = sent;
        while (sent < mark + RANDOM_CHARS) send_string();

        quiet = 1'b1;
        mark  = sent;
        while (sent < mark + CALM_CHARS) send_string();
        push <= 1'b0;

        while (byte_q.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (byte_q.size() != 0)
            flag_mismatch("transactions left over", 16'(byte_q.size()), 16'd0);

        if (err_cnt == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
